### hw/rtl/kfs_pkg.sv
// ----------------------------------------------------------------------------
// kfs_pkg: shared types and constants of the keyed FIFO search block
// Request and status codes, field widths, controller states and the
// command/status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package kfs_pkg;

  // Default parameter values.
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_KEY_BITS    = 16;
  localparam int DEF_VALUE_BITS  = 16;

  // Fixed widths of the stream fields.
  localparam int REQ_BITS         = 2;
  localparam int KEY_FIELD_BITS   = 16;
  localparam int VALUE_FIELD_BITS = 16;
  localparam int STATUS_BITS      = 2;
  localparam int OCC_BITS         = 5;
  localparam int IN_TDATA_BITS    = 32;
  localparam int OUT_TDATA_BITS   = 24;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_APPEND = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_POP    = 2'd2,
    REQ_CLEAR  = 2'd3
  } kfs_req_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } kfs_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DONE
  } kfs_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } kfs_cmd_t;

  typedef struct packed {
    logic is_find;
    logic search_done;
  } kfs_stat_t;

endpackage

### hw/rtl/kfs_ctrl.sv
// ----------------------------------------------------------------------------
// kfs_ctrl: request sequencer
// Accepts one request at a time, runs the search when asked and commits
// the result into the output register once that register is free.
// ----------------------------------------------------------------------------
module kfs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  kfs_pkg::kfs_stat_t  stat_i,
  output kfs_pkg::kfs_cmd_t   cmd_o
);

  kfs_pkg::kfs_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfs_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      kfs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = kfs_pkg::S_EXEC;
        end
      end
      kfs_pkg::S_EXEC: begin
        if (stat_i.is_find) begin
          state_d = kfs_pkg::S_SEARCH;
        end else if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = kfs_pkg::S_IDLE;
        end
      end
      kfs_pkg::S_SEARCH: begin
        cmd_o.step = 1'b1;
        if (stat_i.search_done) begin
          state_d = kfs_pkg::S_DONE;
        end
      end
      kfs_pkg::S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = kfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kfs_pkg::S_IDLE;
      end
    endcase
  end

  // A commit always finds the register free, so it simply sets valid.
  assign out_valid_d = cmd_o.commit || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/kfs_datapath.sv
// ----------------------------------------------------------------------------
// kfs_datapath: ring storage, search pipeline and result register
// Holds the key and value memories, head pointer and entry count, walks
// the ring one entry a cycle for a find, and forms each result.
// ----------------------------------------------------------------------------
module kfs_datapath #(
  parameter int QUEUE_DEPTH = kfs_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = kfs_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = kfs_pkg::DEF_VALUE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  kfs_pkg::kfs_cmd_t                     cmd_i,
  output kfs_pkg::kfs_stat_t                    stat_o,
  input  logic [kfs_pkg::REQ_BITS-1:0]          req_type_i,
  input  logic [kfs_pkg::KEY_FIELD_BITS-1:0]    entry_key_i,
  input  logic [kfs_pkg::VALUE_FIELD_BITS-1:0]  entry_value_i,
  output logic [kfs_pkg::STATUS_BITS-1:0]       status_o,
  output logic [kfs_pkg::VALUE_FIELD_BITS-1:0]  found_value_o,
  output logic [kfs_pkg::OCC_BITS-1:0]          occupancy_o
);

  // Bits above the stream field width are always zero, so they are not stored.
  localparam int KW = (KEY_BITS < kfs_pkg::KEY_FIELD_BITS) ?
                      KEY_BITS : kfs_pkg::KEY_FIELD_BITS;
  localparam int VW = (VALUE_BITS < kfs_pkg::VALUE_FIELD_BITS) ?
                      VALUE_BITS : kfs_pkg::VALUE_FIELD_BITS;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [KW-1:0] key_mem [QUEUE_DEPTH];
  logic [VW-1:0] val_mem [QUEUE_DEPTH];

  kfs_pkg::kfs_req_e req_type_q;
  logic [KW-1:0]     req_key_q;
  logic [VW-1:0]     req_val_q;

  logic [PW-1:0] head_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;
  logic [PW-1:0] ptr_q;
  logic          rd_valid_q;
  logic [KW-1:0] rd_key_q;
  logic [VW-1:0] rd_val_q;
  logic          hit_q;
  logic [VW-1:0] found_q;

  logic          issue;
  logic          more;
  logic          match;
  logic          full;
  logic          empty;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] ptr_inc;

  kfs_pkg::kfs_status_e                 status_c;
  logic signed [VW-1:0]                 found_s;
  logic signed [kfs_pkg::VALUE_FIELD_BITS-1:0] value_c;
  logic [PW-1:0]                        head_c;
  logic [CW-1:0]                        count_c;

  assign more  = idx_q < count_q;
  assign issue = cmd_i.step && more;
  assign match = rd_valid_q && (rd_key_q == req_key_q);
  assign full  = count_q == CW'(QUEUE_DEPTH);
  assign empty = count_q == '0;

  assign stat_o.is_find     = req_type_q == kfs_pkg::REQ_FIND;
  assign stat_o.search_done = match || (!rd_valid_q && !more);

  // The tail stays below twice the depth, so one subtract wraps it.
  assign tail_sum = (PW+1)'(head_q) + (PW+1)'(count_q);
  assign tail     = (tail_sum >= (PW+1)'(QUEUE_DEPTH)) ?
                    PW'(tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
  assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign ptr_inc  = (ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  assign found_s = found_q;

  always_comb begin
    status_c = kfs_pkg::ST_OK;
    value_c  = '0;
    head_c   = head_q;
    count_c  = count_q;
    unique case (req_type_q)
      kfs_pkg::REQ_APPEND: begin
        if (full) begin
          status_c = kfs_pkg::ST_FULL;
        end else begin
          count_c = count_q + 1'b1;
        end
      end
      kfs_pkg::REQ_FIND: begin
        if (hit_q) begin
          value_c = kfs_pkg::VALUE_FIELD_BITS'(found_s);
        end else begin
          status_c = kfs_pkg::ST_MISS;
        end
      end
      kfs_pkg::REQ_POP: begin
        if (empty) begin
          status_c = kfs_pkg::ST_EMPTY;
        end else begin
          head_c  = head_inc;
          count_c = count_q - 1'b1;
        end
      end
      kfs_pkg::REQ_CLEAR: begin
        head_c  = '0;
        count_c = '0;
      end
      default: begin
        status_c = kfs_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      ptr_q      <= '0;
      rd_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q      <= '0;
        ptr_q      <= head_q;
        rd_valid_q <= 1'b0;
        hit_q      <= 1'b0;
      end else if (cmd_i.step) begin
        rd_valid_q <= more;
        if (more) begin
          idx_q <= idx_q + 1'b1;
          ptr_q <= ptr_inc;
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        head_q  <= head_c;
        count_q <= count_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= kfs_pkg::kfs_req_e'(req_type_i);
      req_key_q  <= entry_key_i[KW-1:0];
      req_val_q  <= entry_value_i[VW-1:0];
    end
    if (issue) begin
      rd_key_q <= key_mem[ptr_q];
      rd_val_q <= val_mem[ptr_q];
    end
    if (cmd_i.step && match) begin
      found_q <= rd_val_q;
    end
    if (cmd_i.commit && (req_type_q == kfs_pkg::REQ_APPEND) && !full) begin
      key_mem[tail] <= req_key_q;
      val_mem[tail] <= req_val_q;
    end
    if (cmd_i.commit) begin
      status_o      <= status_c;
      found_value_o <= value_c;
      occupancy_o   <= kfs_pkg::OCC_BITS'(count_c);
    end
  end

endmodule

### hw/rtl/keyed_fifo_search.sv
// ----------------------------------------------------------------------------
// keyed_fifo_search: insertion-ordered key/value queue with key search
// Top level joining the request sequencer and the ring datapath.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the slave stream: s_tuser_i carries the request
// kind (append, find, pop, clear) and s_tdata_i the key and the value. Each
// accepted beat yields exactly one result beat on the master stream with a
// status, the found value and the occupancy after the request.
//
// Throughput. One request is in work at a time. Append, pop and clear pass
// from the execute state straight into the output register. A find walks
// the ring from the head through the single read port of the key memory,
// one entry a cycle, and stops at the first match. A new request is taken
// only once the last one has committed its result.
//
// Reset clears the head pointer, the entry count and all handshake state;
// the stored entries are not cleared and are only read once written. When
// the receiver stalls, the finished result waits in the output register and
// the next request is still accepted and worked on; only its commit waits.
// ----------------------------------------------------------------------------
module keyed_fifo_search #(
  parameter int QUEUE_DEPTH = kfs_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = kfs_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS  = kfs_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  // [15:0] entry_key, [31:16] entry_value
  input  logic [kfs_pkg::IN_TDATA_BITS-1:0]   s_tdata_i,
  // [1:0] req_type
  input  logic [kfs_pkg::REQ_BITS-1:0]        s_tuser_i,
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  // [1:0] status, [17:2] found_value, [22:18] occupancy, [23] zero
  output logic [kfs_pkg::OUT_TDATA_BITS-1:0]  m_tdata_o
);

  kfs_pkg::kfs_cmd_t  cmd;
  kfs_pkg::kfs_stat_t stat;

  logic [kfs_pkg::STATUS_BITS-1:0]      status;
  logic [kfs_pkg::VALUE_FIELD_BITS-1:0] found_value;
  logic [kfs_pkg::OCC_BITS-1:0]         occupancy;

  // The sequencer decides when a beat is taken and when a result commits.
  kfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath owns the ring, the search pipeline and the result register.
  kfs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (s_tuser_i),
    .entry_key_i   (s_tdata_i[kfs_pkg::KEY_FIELD_BITS-1:0]),
    .entry_value_i (s_tdata_i[kfs_pkg::KEY_FIELD_BITS +: kfs_pkg::VALUE_FIELD_BITS]),
    .status_o      (status),
    .found_value_o (found_value),
    .occupancy_o   (occupancy)
  );

  // The spare top bit pads the result to whole bytes.
  assign m_tdata_o = {1'b0, occupancy, found_value, status};

endmodule

### hw/rtl/kfs_checker.sv
// ----------------------------------------------------------------------------
// kfs_checker: port-level checks of the keyed FIFO search block
// Watches the streams of the top level and checks result consistency.
// ----------------------------------------------------------------------------
module kfs_checker #(
  parameter int QUEUE_DEPTH = kfs_pkg::DEF_QUEUE_DEPTH
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_tvalid_i,
  input logic                               s_tready_i,
  input logic                               m_tvalid_i,
  input logic                               m_tready_i,
  input logic [kfs_pkg::OUT_TDATA_BITS-1:0] m_tdata_i
);

  logic [kfs_pkg::STATUS_BITS-1:0]      status;
  logic [kfs_pkg::VALUE_FIELD_BITS-1:0] value;
  logic [kfs_pkg::OCC_BITS-1:0]         occ;

  assign status = m_tdata_i[kfs_pkg::STATUS_BITS-1:0];
  assign value  = m_tdata_i[kfs_pkg::STATUS_BITS +: kfs_pkg::VALUE_FIELD_BITS];
  assign occ    = m_tdata_i[kfs_pkg::STATUS_BITS + kfs_pkg::VALUE_FIELD_BITS +:
                            kfs_pkg::OCC_BITS];

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result beat withdrawn while stalled");

  // Only one request is in work: ready drops straight after a beat is taken.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("request accepted while another is in work");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (status == kfs_pkg::ST_FULL) |->
      (occ == kfs_pkg::OCC_BITS'(QUEUE_DEPTH)))
    else $error("full status with queue not full");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (status == kfs_pkg::ST_EMPTY) |-> (occ == '0))
    else $error("empty status with entries held");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (status != kfs_pkg::ST_OK) |-> (value == '0))
    else $error("non-zero value on a failed request");

endmodule

bind keyed_fifo_search kfs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_kfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_i (s_tready_o),
  .m_tvalid_i (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_i  (m_tdata_o)
);
